// ----- src/trv_pkg.sv -----
// ----------------------------------------------------------------------------
// trv_pkg
// Shared types, constants and helpers of the trail ribbon vertex generator.
// ----------------------------------------------------------------------------
package trv_pkg;

	localparam int unsigned MAX_POINTS_DEF = 32;
	localparam int unsigned FRAC_BITS      = 16;
	localparam int unsigned OFS_SHIFT      = 6;   // Q10.22 -> Q16.16
	localparam int unsigned OFS_W          = 27;
	localparam int unsigned CFG_IDX_W      = 1;
	localparam int unsigned CFG_DATA_W     = 31;

	localparam logic [FRAC_BITS:0]  Q_ONE         = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [30:0]         LIFE_SPAN_RST = 31'd1000000;
	localparam logic                FADE_EN_RST   = 1'b1;

	typedef enum logic [1:0] {
		OP_ADD     = 2'd0,
		OP_ADVANCE = 2'd1,
		OP_BUILD   = 2'd2,
		OP_CLEAR   = 2'd3
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LIFE_SPAN = 1'b0,
		CFG_FADE_EN   = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		opcode_t            opcode;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] up_x;
		logic signed [15:0] up_y;
		logic signed [15:0] up_z;
		logic [15:0]        half_width;
		logic [63:0]        rgba_in;
		logic [15:0]        time_step;
	} trv_in_t;

	typedef struct packed {
		logic signed [31:0] vert_x;
		logic signed [31:0] vert_y;
		logic signed [31:0] vert_z;
		logic               tex_u;
		logic [16:0]        tex_v;
		logic [63:0]        rgba_out;
		logic               last_vertex;
	} trv_out_t;

	// one stored trail point, 256 bits
	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic signed [15:0] ux;
		logic signed [15:0] uy;
		logic signed [15:0] uz;
		logic [15:0]        hw;
		logic [63:0]        rgba;
		logic [31:0]        stamp;
	} point_t;

	typedef struct packed {
		logic        start;
		logic [31:0] num;
		logic [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [FRAC_BITS:0] quo;
	} div_rsp_t;

	// position plus or minus offset, clamped to 32 bits
	function automatic logic signed [31:0] sat_sum(logic signed [31:0] p,
		logic signed [OFS_W-1:0] o, logic sub);
		logic [32:0] pe;
		logic [32:0] oe;
		logic [32:0] s;
		pe = {p[31], p};
		oe = {{(33 - OFS_W){o[OFS_W-1]}}, o};
		s  = sub ? (pe - oe) : (pe + oe);
		if (s[32] != s[31]) begin
			return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
		return s[31:0];
	endfunction

endpackage

// ----- src/trv_div.sv -----
// ----------------------------------------------------------------------------
// trv_div
// Fraction divider: floor(num * 2^16 / den), one quotient bit per cycle.
// num >= den returns one (Q1.16 code 65536), with done raised in the next cycle.
// ----------------------------------------------------------------------------
module trv_div (
	input  logic              clk,
	input  logic              arst_n,
	input  trv_pkg::div_req_t req,
	output trv_pkg::div_rsp_t rsp
);
	import trv_pkg::*;

	localparam int unsigned CNT_W = $clog2(FRAC_BITS + 1);

	logic [31:0]        rem_q;
	logic [FRAC_BITS:0] quo_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [32:0]        rem_sh;
	logic               take;

	assign rem_sh = {rem_q, 1'b0};
	assign take   = (rem_sh >= {1'b0, req.den});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (req.num >= req.den) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= CNT_W'(FRAC_BITS);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// den is held by the sequencer for the whole division
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			quo_q <= (req.num >= req.den) ? Q_ONE : '0;
		end else if (busy_q) begin
			rem_q <= take ? 32'(rem_sh - {1'b0, req.den}) : rem_sh[31:0];
			quo_q <= {quo_q[FRAC_BITS-1:0], take};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

// ----- src/trail_ribbon_vertex_generator.sv -----
// ----------------------------------------------------------------------------
// trail_ribbon_vertex_generator
// Ring of timestamped trail points that expands into triangle-strip vertices.
// ----------------------------------------------------------------------------
// Add and clear stay idle. Advance reads and checks the oldest point, and
// again for each expired point dropped. Build with n >= 2 points emits two
// vertex beats per point, paced by the 16-step fraction divider, run for the
// v coordinate and, with a nonzero life span, for the normalized age, plus
// one memory read and four passes through the shared 17x18 multiplier (three
// offsets and the faded alpha). Input is stalled while an operation runs;
// the output register lets the last vertex wait while the next item enters.
module trail_ribbon_vertex_generator #(
	parameter int unsigned MAX_POINTS = trv_pkg::MAX_POINTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  trv_pkg::trv_in_t                    in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output trv_pkg::trv_out_t                   out_data,
	input  logic                                cfg_we,
	input  logic [trv_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [trv_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
	import trv_pkg::*;

	localparam int unsigned IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int unsigned CW = $clog2(MAX_POINTS + 1);

	typedef enum logic [10:0] {
		ST_IDLE    = 11'b000_0000_0001,
		ST_ADV_RD  = 11'b000_0000_0010,
		ST_ADV_CHK = 11'b000_0000_0100,
		ST_BLD_RD  = 11'b000_0000_1000,
		ST_V_GO    = 11'b000_0001_0000,
		ST_V_WAIT  = 11'b000_0010_0000,
		ST_A_GO    = 11'b000_0100_0000,
		ST_A_WAIT  = 11'b000_1000_0000,
		ST_MUL     = 11'b001_0000_0000,
		ST_MUL_END = 11'b010_0000_0000,
		ST_EMIT    = 11'b100_0000_0000
	} state_t;

	state_t              state_q;
	logic                side_q;      // 0: plus-up vertex, 1: minus-up vertex
	logic [30:0]         life_span_q;
	logic                fade_en_q;
	logic [IW-1:0]       ws_q;
	logic [CW-1:0]       lc_q;
	logic [31:0]         elapsed_q;
	logic [IW-1:0]       pt_idx_q;
	logic [IW-1:0]       rd_slot_q;
	logic [1:0]          mul_idx_q;
	logic [FRAC_BITS:0]  v_q;
	logic [FRAC_BITS:0]  nage_q;
	logic signed [34:0]  prod_s1;
	logic [1:0]          prod_idx_s1;
	logic                prod_vld_s1;
	logic signed [OFS_W-1:0] ox_q, oy_q, oz_q;
	logic [15:0]         alpha_q;
	logic                out_valid_q;
	trv_out_t            out_q;

	point_t              pt_mem_q [MAX_POINTS];
	point_t              rd_pt_q;
	point_t              pt_wr;

	logic                in_accept;
	logic                out_free;
	logic                emit_load;
	logic                is_last;
	logic [CW:0]         tail_sum;
	logic [IW-1:0]       tail;
	logic [IW-1:0]       ws_inc;
	logic [IW-1:0]       rd_slot_inc;
	logic [31:0]         age;
	logic                mem_we;
	logic                mem_re;
	logic [IW-1:0]       rd_addr;
	logic signed [16:0]  mul_a;
	logic signed [17:0]  mul_b;
	logic signed [34:0]  mul_prod;
	logic [FRAC_BITS:0]  keep;
	div_req_t            div_req;
	div_rsp_t            div_rsp;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign emit_load = (state_q == ST_EMIT) && out_free;
	assign is_last   = (CW'(pt_idx_q) == lc_q - CW'(1));

	// oldest live slot: (ws + MAX - count) mod MAX
	assign tail_sum = (CW + 1)'(ws_q) + (CW + 1)'(MAX_POINTS) - (CW + 1)'(lc_q);
	assign tail     = (tail_sum >= (CW + 1)'(MAX_POINTS)) ?
		IW'(tail_sum - (CW + 1)'(MAX_POINTS)) : IW'(tail_sum);
	assign ws_inc      = (ws_q == IW'(MAX_POINTS - 1)) ? '0 : ws_q + IW'(1);
	assign rd_slot_inc = (rd_slot_q == IW'(MAX_POINTS - 1)) ? '0 : rd_slot_q + IW'(1);

	assign age = elapsed_q - rd_pt_q.stamp;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			life_span_q <= LIFE_SPAN_RST;
			fade_en_q   <= FADE_EN_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				CFG_LIFE_SPAN: life_span_q <= cfg_wdata;
				CFG_FADE_EN:   fade_en_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// ---------------- point memory ----------------
	assign pt_wr = '{px: in_data.pos_x, py: in_data.pos_y, pz: in_data.pos_z,
		ux: in_data.up_x, uy: in_data.up_y, uz: in_data.up_z,
		hw: in_data.half_width, rgba: in_data.rgba_in, stamp: elapsed_q};
	assign mem_we  = in_accept && (in_data.opcode == OP_ADD);
	assign mem_re  = (state_q == ST_ADV_RD) || (state_q == ST_BLD_RD);
	assign rd_addr = (state_q == ST_ADV_RD) ? tail : rd_slot_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			pt_mem_q[ws_q] <= pt_wr;
		end
		if (mem_re) begin
			rd_pt_q <= pt_mem_q[rd_addr];
		end
	end

	// ---------------- shared divider ----------------
	assign div_req.start = (state_q == ST_V_GO) ||
		((state_q == ST_A_GO) && (life_span_q != '0));
	assign div_req.num = ((state_q == ST_V_GO) || (state_q == ST_V_WAIT)) ?
		32'(pt_idx_q) : age;
	assign div_req.den = ((state_q == ST_V_GO) || (state_q == ST_V_WAIT)) ?
		32'(lc_q - CW'(1)) : {1'b0, life_span_q};

	trv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ---------------- shared multiplier ----------------
	assign keep = Q_ONE - nage_q;

	always_comb begin
		case (mul_idx_q)
			2'd0: mul_a = {rd_pt_q.ux[15], rd_pt_q.ux};
			2'd1: mul_a = {rd_pt_q.uy[15], rd_pt_q.uy};
			2'd2: mul_a = {rd_pt_q.uz[15], rd_pt_q.uz};
			default: mul_a = {1'b0, rd_pt_q.rgba[15:0]};
		endcase
		mul_b = (mul_idx_q == 2'd3) ? {1'b0, keep} : {2'b00, rd_pt_q.hw};
	end
	assign mul_prod = mul_a * mul_b;

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			side_q      <= 1'b0;
			ws_q        <= '0;
			lc_q        <= '0;
			elapsed_q   <= '0;
			pt_idx_q    <= '0;
			rd_slot_q   <= '0;
			mul_idx_q   <= '0;
			prod_vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			prod_vld_s1 <= (state_q == ST_MUL);
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						case (in_data.opcode)
							OP_ADD: begin
								ws_q <= ws_inc;
								if (lc_q != CW'(MAX_POINTS)) begin
									lc_q <= lc_q + CW'(1);
								end
							end
							OP_ADVANCE: begin
								elapsed_q <= elapsed_q + 32'(in_data.time_step);
								state_q   <= ST_ADV_RD;
							end
							OP_BUILD: begin
								if (lc_q >= CW'(2)) begin
									pt_idx_q  <= '0;
									rd_slot_q <= tail;
									state_q   <= ST_BLD_RD;
								end
							end
							OP_CLEAR: begin
								ws_q <= '0;
								lc_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_ADV_RD: state_q <= ST_ADV_CHK;
				ST_ADV_CHK: begin
					if ((lc_q != '0) && (age > {1'b0, life_span_q})) begin
						lc_q    <= lc_q - CW'(1);
						state_q <= ST_ADV_RD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_BLD_RD: state_q <= ST_V_GO;
				ST_V_GO:   state_q <= ST_V_WAIT;
				ST_V_WAIT: begin
					if (div_rsp.done) begin
						state_q <= ST_A_GO;
					end
				end
				ST_A_GO: begin
					mul_idx_q <= '0;
					state_q   <= (life_span_q == '0) ? ST_MUL : ST_A_WAIT;
				end
				ST_A_WAIT: begin
					if (div_rsp.done) begin
						mul_idx_q <= '0;
						state_q   <= ST_MUL;
					end
				end
				ST_MUL: begin
					mul_idx_q <= mul_idx_q + 2'd1;
					if (mul_idx_q == 2'd3) begin
						state_q <= ST_MUL_END;
					end
				end
				ST_MUL_END: begin
					side_q  <= 1'b0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						side_q <= 1'b1;
						if (side_q) begin
							if (is_last) begin
								state_q <= ST_IDLE;
							end else begin
								pt_idx_q  <= pt_idx_q + IW'(1);
								rd_slot_q <= rd_slot_inc;
								state_q   <= ST_BLD_RD;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if ((state_q == ST_V_WAIT) && div_rsp.done) begin
			v_q <= div_rsp.quo;
		end
		if ((state_q == ST_A_GO) && (life_span_q == '0)) begin
			nage_q <= '0;
		end else if ((state_q == ST_A_WAIT) && div_rsp.done) begin
			nage_q <= div_rsp.quo;
		end
		if (state_q == ST_MUL) begin
			prod_s1     <= mul_prod;
			prod_idx_s1 <= mul_idx_q;
		end
		if (prod_vld_s1) begin
			case (prod_idx_s1)
				2'd0: ox_q <= prod_s1[OFS_W+OFS_SHIFT-1:OFS_SHIFT];
				2'd1: oy_q <= prod_s1[OFS_W+OFS_SHIFT-1:OFS_SHIFT];
				2'd2: oz_q <= prod_s1[OFS_W+OFS_SHIFT-1:OFS_SHIFT];
				default: alpha_q <= prod_s1[31:16];
			endcase
		end
		if (emit_load) begin
			out_q.vert_x      <= sat_sum(rd_pt_q.px, ox_q, side_q);
			out_q.vert_y      <= sat_sum(rd_pt_q.py, oy_q, side_q);
			out_q.vert_z      <= sat_sum(rd_pt_q.pz, oz_q, side_q);
			out_q.tex_u       <= side_q;
			out_q.tex_v       <= v_q;
			out_q.rgba_out    <= fade_en_q ? {rd_pt_q.rgba[63:16], alpha_q} : rd_pt_q.rgba;
			out_q.last_vertex <= side_q && is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// ---------------- assertions ----------------
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		lc_q <= CW'(MAX_POINTS))
		else $error("live count above ring depth");

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_last_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_load && side_q && is_last) |=>
		(state_q == ST_IDLE) && out_valid_q && out_q.last_vertex)
		else $error("final vertex did not close the build");

	a_build_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL || state_q == ST_EMIT || state_q == ST_V_WAIT)
		|=> $stable(lc_q))
		else $error("live count changed during build");

endmodule

// ----- test/trail_ribbon_vertex_generator_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trail_ribbon_vertex_generator_tb
// Self-checking bench for the trail ribbon vertex generator. A queue-fed
// driver offers add, advance, build and clear beats with random or no gaps.
// A clocked monitor with random stalls compares every vertex beat, field by
// field, with the output of a local model of the point ring. Phases cover
// the register extremes, expiry, receiver back-pressure and long ages.
// ----------------------------------------------------------------------------
module trail_ribbon_vertex_generator_tb;
	import trv_pkg::*;

	localparam int unsigned NPTS = MAX_POINTS_DEF;

	typedef struct {
		trv_in_t     item;
		int unsigned gap;
	} pend_beat_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	trv_in_t               in_data   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	trv_out_t              out_data;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  hold_go   = 1'b0;

	// local copy of the ring and its registers
	point_t                ring_pts [NPTS] = '{default: '0};
	int unsigned           ring_head = 0;
	int unsigned           ring_live = 0;
	logic [31:0]           tick_now  = '0;
	logic [30:0]           cfg_life  = LIFE_SPAN_RST;
	logic                  cfg_fade  = FADE_EN_RST;

	trv_out_t              vert_expect[$];
	pend_beat_t            beat_queue[$];
	pend_beat_t            src_cur;
	logic                  src_loaded = 1'b0;
	bit                    src_idle   = 1'b1;
	bit                    sink_idle  = 1'b1;
	int unsigned           sink_wait  = 0;
	int unsigned           hold_left  = 0;
	int unsigned           fail_cnt   = 0;

	trail_ribbon_vertex_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic int unsigned oldest_slot();
		return (ring_head + NPTS - ring_live) % NPTS;
	endfunction

	function automatic logic [31:0] age_of(input int unsigned slot);
		return tick_now - ring_pts[slot].stamp;
	endfunction

	function automatic logic signed [31:0] clamp32(input longint s);
		if (s > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (s < -64'sh8000_0000) return 32'sh8000_0000;
		return s[31:0];
	endfunction

	// update the ring for one accepted beat and queue the strip it produces
	task automatic apply_trail_op(input trv_in_t it);
		point_t            pt;
		trv_out_t          v;
		int unsigned       first;
		longint unsigned   nage;
		longint unsigned   tv;
		longint unsigned   alpha;
		longint            ox;
		longint            oy;
		longint            oz;
		case (it.opcode)
			OP_ADD: begin
				pt.px    = it.pos_x;
				pt.py    = it.pos_y;
				pt.pz    = it.pos_z;
				pt.ux    = it.up_x;
				pt.uy    = it.up_y;
				pt.uz    = it.up_z;
				pt.hw    = it.half_width;
				pt.rgba  = it.rgba_in;
				pt.stamp = tick_now;
				ring_pts[ring_head] = pt;
				ring_head = (ring_head + 1) % NPTS;
				if (ring_live < NPTS) ring_live++;
			end
			OP_ADVANCE: begin
				tick_now = tick_now + it.time_step;
				while (ring_live != 0 && age_of(oldest_slot()) > cfg_life) ring_live--;
			end
			OP_CLEAR: begin
				ring_head = 0;
				ring_live = 0;
			end
			default: begin
				if (ring_live >= 2) begin
					first = oldest_slot();
					for (int unsigned i = 0; i < ring_live; i++) begin
						pt = ring_pts[(first + i) % NPTS];
						nage = 0;
						if (cfg_life != 0) begin
							nage = (longint'(age_of((first + i) % NPTS)) << 16) / cfg_life;
							if (nage > 65536) nage = 65536;
						end
						tv = (longint'(i) << 16) / (ring_live - 1);
						// Q2.14 * Q8.8 -> Q16.16, rounded toward minus infinity
						ox = (longint'(pt.ux) * longint'(pt.hw)) >>> OFS_SHIFT;
						oy = (longint'(pt.uy) * longint'(pt.hw)) >>> OFS_SHIFT;
						oz = (longint'(pt.uz) * longint'(pt.hw)) >>> OFS_SHIFT;
						v.rgba_out = pt.rgba;
						if (cfg_fade) begin
							alpha = pt.rgba[15:0];
							alpha = (alpha * (65536 - nage)) >> 16;
							v.rgba_out[15:0] = alpha[15:0];
						end
						v.tex_v = tv[16:0];
						for (int s = 0; s < 2; s++) begin
							v.vert_x = clamp32(s ? longint'(pt.px) - ox : longint'(pt.px) + ox);
							v.vert_y = clamp32(s ? longint'(pt.py) - oy : longint'(pt.py) + oy);
							v.vert_z = clamp32(s ? longint'(pt.pz) - oz : longint'(pt.pz) + oz);
							v.tex_u = (s == 1);
							v.last_vertex = (i == ring_live - 1) && (s == 1);
							vert_expect.insert(vert_expect.size(), v);
						end
					end
				end
			end
		endcase
	endtask

	// driver: one pending beat at a time, after its drawn gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			src_loaded = 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) apply_trail_op(in_data);
			if (!src_loaded && beat_queue.size() != 0) begin
				src_cur = beat_queue.pop_front();
				src_loaded = 1'b1;
			end
			if (src_loaded && src_cur.gap == 0) begin
				in_data <= src_cur.item;
				in_valid <= 1'b1;
				src_loaded = 1'b0;
			end else begin
				in_valid <= 1'b0;
				if (src_loaded) src_cur.gap--;
			end
		end
	end

	task automatic cmp_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
			fail_cnt++;
		end
	endtask

	// monitor: random stall per vertex beat, plus the long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			sink_wait = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (vert_expect.size() == 0) begin
					$display("%0t: expected no vertex beat, got %h", $time, out_data);
					fail_cnt++;
				end else begin
					cmp_field("vert_x", vert_expect[0].vert_x, out_data.vert_x);
					cmp_field("vert_y", vert_expect[0].vert_y, out_data.vert_y);
					cmp_field("vert_z", vert_expect[0].vert_z, out_data.vert_z);
					cmp_field("tex_u", vert_expect[0].tex_u, out_data.tex_u);
					cmp_field("tex_v", vert_expect[0].tex_v, out_data.tex_v);
					cmp_field("rgba_out", vert_expect[0].rgba_out, out_data.rgba_out);
					cmp_field("last_vertex", vert_expect[0].last_vertex, out_data.last_vertex);
					void'(vert_expect.pop_front());
				end
				sink_wait = sink_idle ? $urandom_range(0, 10) : 0;
			end else if (sink_wait != 0) begin
				sink_wait--;
			end
			out_stall <= (sink_wait != 0) || (hold_left != 0);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_go) begin
			hold_left <= 800;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return 32'h7FFF_FFFF - $urandom_range(0, 1 << 25);
			1: return 32'h8000_0000 + $urandom_range(0, 1 << 25);
			default: return $urandom;
		endcase
	endfunction

	function automatic trv_in_t random_item(input opcode_t op, input int unsigned step_lim);
		trv_in_t it;
		it.opcode     = op;
		it.pos_x      = rand_coord();
		it.pos_y      = rand_coord();
		it.pos_z      = rand_coord();
		it.up_x       = 16'($urandom);
		it.up_y       = 16'($urandom);
		it.up_z       = 16'($urandom);
		it.half_width = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
		it.rgba_in    = {$urandom, $urandom};
		it.time_step  = ($urandom_range(0, 3) == 0) ? 16'($urandom)
			: 16'($urandom_range(0, step_lim));
		return it;
	endfunction

	function automatic opcode_t pick_op();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 48) return OP_ADD;
		if (r < 70) return OP_ADVANCE;
		if (r < 96) return OP_BUILD;
		return OP_CLEAR;
	endfunction

	task automatic offer(input trv_in_t it);
		pend_beat_t b;
		b.item = it;
		b.gap = src_idle ? $urandom_range(0, 10) : 0;
		beat_queue.insert(beat_queue.size(), b);
	endtask

	task automatic offer_op(input opcode_t op);
		offer(random_item(op, 0));
	endtask

	task automatic offer_step(input logic [15:0] step);
		trv_in_t it;
		it = random_item(OP_ADVANCE, 0);
		it.time_step = step;
		offer(it);
	endtask

	task automatic run_batch(input int n, input int unsigned step_lim);
		repeat (n) offer(random_item(pick_op(), step_lim));
	endtask

	task automatic wait_sent();
		do @(negedge clk); while (beat_queue.size() != 0 || src_loaded || in_valid);
	endtask

	// everything sent and every vertex back; then let advance finish dropping
	task automatic settle();
		do @(negedge clk); while (beat_queue.size() != 0 || src_loaded || in_valid
			|| vert_expect.size() != 0);
		repeat (100) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		if (idx == CFG_LIFE_SPAN) cfg_life = val;
		else cfg_fade = val[0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		trv_in_t         it;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: empty, single-point and multi-point builds, saturation, fade, clear
		offer_op(OP_BUILD);
		it = random_item(OP_ADD, 0);
		it.pos_x = 32'h7FFF_FFFF;
		it.pos_y = 32'h7FFF_FFFF;
		it.pos_z = 32'h7FFF_FFFF;
		it.up_x = 16'h7FFF;
		it.up_y = 16'h7FFF;
		it.up_z = 16'h7FFF;
		it.half_width = 16'hFFFF;
		it.rgba_in = '1;
		offer(it);
		offer_op(OP_BUILD);
		it.pos_x = 32'h8000_0000;
		it.pos_y = 32'h8000_0000;
		it.pos_z = 32'h8000_0000;
		it.up_x = 16'h8000;
		it.up_y = 16'h8000;
		it.up_z = 16'h8000;
		it.rgba_in = '0;
		offer(it);
		offer_op(OP_BUILD);
		offer_step(16'hFFFF);
		it = random_item(OP_ADD, 0);
		it.pos_x = '0;
		it.pos_y = '0;
		it.pos_z = '0;
		it.up_x = '0;
		it.up_y = '0;
		it.up_z = '0;
		it.half_width = '0;
		offer(it);
		offer_op(OP_BUILD);
		offer_op(OP_CLEAR);
		offer_op(OP_BUILD);
		settle();

		// short lifetime, no fade: expiry from the oldest end
		write_reg(CFG_LIFE_SPAN, 31'd100);
		write_reg(CFG_FADE_EN, 31'd0);
		offer_op(OP_ADD);
		offer_step(16'd60);
		offer_op(OP_ADD);
		offer_step(16'd60);
		offer_op(OP_ADD);
		offer_op(OP_BUILD);
		offer_step(16'd200);
		offer_op(OP_BUILD);
		settle();

		// zero lifetime: age zero survives, any nonzero age drops
		write_reg(CFG_LIFE_SPAN, 31'd0);
		write_reg(CFG_FADE_EN, 31'd1);
		offer_op(OP_ADD);
		offer_op(OP_ADD);
		offer_step(16'd0);
		offer_op(OP_BUILD);
		offer_step(16'd1);
		offer_op(OP_BUILD);
		settle();

		// fill past capacity so the oldest points get overwritten
		write_reg(CFG_LIFE_SPAN, 31'($urandom_range(20000, 400000)));
		repeat (34) offer_op(OP_ADD);
		offer_op(OP_BUILD);
		run_batch(20, 2000);
		settle();

		// long receiver hold-off while full-ring builds keep coming
		offer_op(OP_CLEAR);
		repeat (32) offer_op(OP_ADD);
		wait_sent();
		@(posedge clk);
		hold_go <= 1'b1;
		@(posedge clk);
		hold_go <= 1'b0;
		repeat (4) offer_op(OP_BUILD);
		offer_op(OP_ADD);
		offer_op(OP_BUILD);
		settle();

		// longest lifetime, no fade, back to back on both sides
		write_reg(CFG_LIFE_SPAN, 31'h7FFF_FFFF);
		write_reg(CFG_FADE_EN, 31'd0);
		src_idle = 1'b0;
		sink_idle = 1'b0;
		run_batch(30, 65535);
		settle();

		src_idle = 1'b1;
		sink_idle = 1'b1;
		write_reg(CFG_LIFE_SPAN, 31'($urandom_range(1, 3000)));
		write_reg(CFG_FADE_EN, 31'd1);
		run_batch(30, 500);
		settle();

		write_reg(CFG_LIFE_SPAN, 31'd0);
		write_reg(CFG_FADE_EN, 31'($urandom_range(0, 1)));
		sink_idle = 1'b0;
		run_batch(20, 3);
		settle();

		// widest lifetime with fade: points aged over large tick steps
		write_reg(CFG_LIFE_SPAN, 31'h7FFF_FFFF);
		write_reg(CFG_FADE_EN, 31'd1);
		src_idle = 1'b0;
		sink_idle = 1'b1;
		offer_op(OP_CLEAR);
		repeat (5) begin
			offer_op(OP_ADD);
			offer_step(16'd50000);
		end
		offer_op(OP_ADD);
		offer_op(OP_BUILD);
		settle();

		if (fail_cnt == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
src/trv_pkg.sv
src/trv_div.sv
src/trail_ribbon_vertex_generator.sv
test/trail_ribbon_vertex_generator_tb.sv
